// ===== hw/rtl/tcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Store geometry
    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLUMNS = 128;
    localparam int STORE_CELLS = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int AREA_W      = ADDR_W + 1;
    localparam int ROWS_W      = 6;
    localparam int COLS_W      = 8;
    localparam int CELL_W      = 16;

    // Character codes and blank cell
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] BLANK_ATTR = 8'h07;
    localparam logic [2:0] TAB_SPACES = 3'd4;

    // Configuration register indexes and reset values
    localparam logic       CFG_ROWS      = 1'b0;
    localparam logic       CFG_COLUMNS   = 1'b1;
    localparam logic [5:0] ROWS_RESET    = 6'd25;
    localparam logic [7:0] COLUMNS_RESET = 8'd80;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_PUT   = 3'd0,
        KIND_SET   = 3'd1,
        KIND_MOVE  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_DIV,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Cursor update selection
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_SET,
        CUR_MOVE,
        CUR_NEWLINE,
        CUR_KEEP,
        CUR_ZERO
    } cur_op_t;

    // Store access selection
    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_BLANK,
        MEM_READ
    } mem_op_t;

    // Sweep counter control
    typedef enum logic [1:0] {
        SCAN_HOLD,
        SCAN_ZERO,
        SCAN_INC
    } scan_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     latch_item;
        cur_op_t  cur_op;
        mem_op_t  mem_op;
        scan_op_t scan_op;
        logic     scroll_move;
        logic     div_start;
        logic     set_scrolled;
        logic     out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  ch_is_nl;
        logic  ch_is_tab;
        logic  pos_ok;
        logic  move_ok;
        logic  put_wrap;
        logic  nl_wrap;
        logic  scan_lt_keep;
        logic  scan_end_area;
        logic  scan_end_store;
        logic  div_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcce_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: configuration, cursor, screen store, remainder unit and result.
// ----------------------------------------------------------------------------
module tcce_dp
    import tcce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic [2:0]        in_kind,
    input  wire logic [7:0]        in_char,
    input  wire logic [7:0]        in_attr,
    input  wire logic [ADDR_W-1:0] in_pos,
    input  wire logic [12:0]       in_off,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic [ADDR_W-1:0]      out_cursor,
    output logic [7:0]             out_char,
    output logic [7:0]             out_attr,
    output logic                   out_scrolled
);

    // Configuration
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;

    // Item and cursor
    logic [2:0]        item_kind_reg;
    logic [7:0]        item_char_reg;
    logic [7:0]        item_attr_reg;
    logic [ADDR_W-1:0] item_pos_reg;
    logic [12:0]       item_off_reg;
    logic [ADDR_W-1:0] cursor_reg;
    logic [ADDR_W-1:0] cursor_next;
    logic              scrolled_reg;

    // Sweep counter and move pipeline
    logic [ADDR_W-1:0] scan_reg;
    logic [ADDR_W-1:0] scan_next;
    logic              mv_pend_reg;
    logic [ADDR_W-1:0] mv_addr_reg;

    // Remainder unit
    logic [7:0]        rem_reg;
    logic [ADDR_W-1:0] dvd_reg;
    logic [3:0]        div_cnt_reg;
    logic [7:0]        div_trial;

    // Store
    logic [CELL_W-1:0] mem [STORE_CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Geometry and arithmetic
    logic [ROWS_W-1:0]    eff_rows;
    logic [COLS_W-1:0]    eff_cols;
    logic [AREA_W-1:0]    total;
    logic [AREA_W-1:0]    keep;
    logic [AREA_W-1:0]    cur_inc;
    logic signed [AREA_W:0] move_pos;
    logic [AREA_W-1:0]    nl_pos;
    logic [AREA_W-1:0]    scroll_src;
    logic [7:0]           put_char;

    // Result register
    logic [ADDR_W-1:0] res_cursor_reg;
    logic [7:0]        res_char_reg;
    logic [7:0]        res_attr_reg;
    logic              res_scrolled_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLUMNS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS:    rows_reg <= cfg_wdata[ROWS_W-1:0];
                CFG_COLUMNS: cols_reg <= cfg_wdata;
                default:     rows_reg <= rows_reg;
            endcase
        end
    end

    // Clamp geometry, derive area sizes and compute cursor and scroll addresses
    always_comb
    begin
        if (rows_reg == '0)
            eff_rows = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = rows_reg;
        if (cols_reg == '0)
            eff_cols = COLS_W'(1);
        else if (cols_reg > COLS_W'(MAX_COLUMNS))
            eff_cols = COLS_W'(MAX_COLUMNS);
        else
            eff_cols = cols_reg;
        total      = AREA_W'(eff_rows) * AREA_W'(eff_cols);
        keep       = total - AREA_W'(eff_cols);
        cur_inc    = {1'b0, cursor_reg} + AREA_W'(1);
        move_pos   = $signed({2'b00, cursor_reg})
                   + $signed({item_off_reg[12], item_off_reg});
        nl_pos     = {1'b0, cursor_reg} - AREA_W'(rem_reg) + AREA_W'(eff_cols);
        scroll_src = {1'b0, scan_reg} + AREA_W'(eff_cols);
        put_char   = (item_char_reg == CH_TAB) ? BLANK_CHAR : item_char_reg;
    end

    // Report status
    always_comb
    begin
        status.kind           = kind_t'(item_kind_reg);
        status.ch_is_nl       = (item_char_reg == CH_NEWLINE);
        status.ch_is_tab      = (item_char_reg == CH_TAB);
        status.pos_ok         = ({1'b0, item_pos_reg} < total);
        status.move_ok        = !move_pos[AREA_W] && (move_pos[AREA_W-1:0] < total);
        status.put_wrap       = (cur_inc >= total);
        status.nl_wrap        = (nl_pos >= total);
        status.scan_lt_keep   = ({1'b0, scan_reg} < keep);
        status.scan_end_area  = ({1'b0, scan_reg} == (total - AREA_W'(1)));
        status.scan_end_store = &scan_reg;
        status.div_busy       = (div_cnt_reg != '0);
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_kind_reg <= in_kind;
            item_char_reg <= in_char;
            item_attr_reg <= in_attr;
            item_pos_reg  <= in_pos;
            item_off_reg  <= in_off;
        end
    end

    // Select next cursor
    always_comb
    begin
        unique case (cmd.cur_op)
            CUR_HOLD:    cursor_next = cursor_reg;
            CUR_INC:     cursor_next = cur_inc[ADDR_W-1:0];
            CUR_SET:     cursor_next = item_pos_reg;
            CUR_MOVE:    cursor_next = move_pos[ADDR_W-1:0];
            CUR_NEWLINE: cursor_next = nl_pos[ADDR_W-1:0];
            CUR_KEEP:    cursor_next = keep[ADDR_W-1:0];
            CUR_ZERO:    cursor_next = '0;
            default:     cursor_next = cursor_reg;
        endcase
    end

    // Select next sweep address
    always_comb
    begin
        unique case (cmd.scan_op)
            SCAN_HOLD: scan_next = scan_reg;
            SCAN_ZERO: scan_next = '0;
            SCAN_INC:  scan_next = scan_reg + ADDR_W'(1);
            default:   scan_next = scan_reg;
        endcase
    end

    // Hold cursor, sweep counter, scroll flag and move pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            scan_reg     <= '0;
            scrolled_reg <= 1'b0;
            mv_pend_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            scan_reg    <= scan_next;
            mv_pend_reg <= cmd.scroll_move && status.scan_lt_keep;
            if (cmd.latch_item)
                scrolled_reg <= 1'b0;
            else if (cmd.set_scrolled)
                scrolled_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_addr_reg <= scan_reg;
    end

    // Step the remainder unit one dividend bit per cycle
    assign div_trial = {rem_reg[6:0], dvd_reg[ADDR_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= 4'(ADDR_W);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cursor_reg;
        end
        else if (div_cnt_reg != '0)
        begin
            rem_reg <= (div_trial >= eff_cols) ? (div_trial - eff_cols) : div_trial;
            dvd_reg <= {dvd_reg[ADDR_W-2:0], 1'b0};
        end
    end

    // Arbitrate the store ports; a pending scroll move owns the write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = scan_reg;
        mem_wdata = {BLANK_ATTR, BLANK_CHAR};
        mem_re    = 1'b0;
        mem_raddr = item_pos_reg;
        if (mv_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = mv_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else
        begin
            unique case (cmd.mem_op)
                MEM_PUT:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cursor_reg;
                    mem_wdata = {item_attr_reg, put_char};
                end
                MEM_BLANK:
                begin
                    mem_we = 1'b1;
                end
                MEM_READ:
                begin
                    mem_re = 1'b1;
                end
                MEM_NONE:
                begin
                    mem_we = 1'b0;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        if (cmd.scroll_move && status.scan_lt_keep)
        begin
            mem_re    = 1'b1;
            mem_raddr = scroll_src[ADDR_W-1:0];
        end
    end

    // Screen store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_cursor_reg   <= cursor_reg;
            res_scrolled_reg <= scrolled_reg;
            if (kind_t'(item_kind_reg) == KIND_READ)
            begin
                res_char_reg <= rd_data_reg[7:0];
                res_attr_reg <= rd_data_reg[15:8];
            end
            else
            begin
                res_char_reg <= '0;
                res_attr_reg <= '0;
            end
        end
    end

    assign out_cursor   = res_cursor_reg;
    assign out_char     = res_char_reg;
    assign out_attr     = res_attr_reg;
    assign out_scrolled = res_scrolled_reg;

`ifndef SYNTHESIS
    a_move_write_alone : assert property (@(posedge clk) disable iff (!rst_n)
        mv_pend_reg |-> (cmd.mem_op == MEM_NONE))
        else $error("scroll move write collides with another store write");

    a_div_idle_start : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (div_cnt_reg == '0))
        else $error("remainder unit restarted while busy");

    a_scroll_src_in_area : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scroll_move && status.scan_lt_keep) |-> (scroll_src < total))
        else $error("scroll source outside the area in use");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/tcce_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ctrl
// Controller: sequences store sweeps, puts, newline and output handshake.
// ----------------------------------------------------------------------------
module tcce_ctrl
    import tcce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] put_left_reg;
    logic [2:0] put_left_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State, put count and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            put_left_reg  <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            put_left_reg  <= put_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        put_left_next    = put_left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        in_ready         = 1'b0;
        cmd.latch_item   = 1'b0;
        cmd.cur_op       = CUR_HOLD;
        cmd.mem_op       = MEM_NONE;
        cmd.scan_op      = SCAN_HOLD;
        cmd.scroll_move  = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.set_scrolled = 1'b0;
        cmd.out_load     = 1'b0;

        unique case (state_reg)
            // Blank the whole store after reset
            ST_INIT:
            begin
                cmd.mem_op = MEM_BLANK;
                if (status.scan_end_store)
                    state_next = ST_IDLE;
                else
                    cmd.scan_op = SCAN_INC;
            end

            // Take a request
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end

            // Dispatch on kind
            ST_DECODE:
            begin
                unique case (status.kind)
                    KIND_PUT:
                    begin
                        if (status.ch_is_nl)
                        begin
                            cmd.div_start = 1'b1;
                            put_left_next = 3'd1;
                            state_next    = ST_DIV;
                        end
                        else
                        begin
                            put_left_next = status.ch_is_tab ? TAB_SPACES : 3'd1;
                            state_next    = ST_PUT;
                        end
                    end
                    KIND_SET:
                    begin
                        if (status.pos_ok)
                            cmd.cur_op = CUR_SET;
                        state_next = ST_DONE;
                    end
                    KIND_MOVE:
                    begin
                        if (status.move_ok)
                            cmd.cur_op = CUR_MOVE;
                        state_next = ST_DONE;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.scan_op = SCAN_ZERO;
                        state_next  = ST_CLEAR;
                    end
                    KIND_READ:
                    begin
                        cmd.mem_op = MEM_READ;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Write one cell and advance, or start a scroll
            ST_PUT:
            begin
                cmd.mem_op = MEM_PUT;
                if (status.put_wrap)
                begin
                    cmd.set_scrolled = 1'b1;
                    cmd.scan_op      = SCAN_ZERO;
                    state_next       = ST_SCROLL;
                end
                else
                begin
                    cmd.cur_op = CUR_INC;
                    if (put_left_reg == 3'd1)
                        state_next = ST_DONE;
                    else
                        put_left_next = put_left_reg - 3'd1;
                end
            end

            // Wait for the column remainder, then go to the next row start
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    if (status.nl_wrap)
                    begin
                        cmd.set_scrolled = 1'b1;
                        cmd.scan_op      = SCAN_ZERO;
                        state_next       = ST_SCROLL;
                    end
                    else
                    begin
                        cmd.cur_op = CUR_NEWLINE;
                        state_next = ST_DONE;
                    end
                end
            end

            // Copy each row up by one; the last write drains at the end
            ST_SCROLL:
            begin
                cmd.scroll_move = 1'b1;
                if (status.scan_lt_keep)
                    cmd.scan_op = SCAN_INC;
                else
                    state_next = ST_BLANK;
            end

            // Blank the last row, park the cursor at its start and resume any tab spaces left
            ST_BLANK:
            begin
                cmd.mem_op = MEM_BLANK;
                if (status.scan_end_area)
                begin
                    cmd.cur_op = CUR_KEEP;
                    if (put_left_reg > 3'd1)
                    begin
                        put_left_next = put_left_reg - 3'd1;
                        state_next    = ST_PUT;
                    end
                    else
                        state_next = ST_DONE;
                end
                else
                    cmd.scan_op = SCAN_INC;
            end

            // Blank the area in use and home the cursor
            ST_CLEAR:
            begin
                cmd.mem_op = MEM_BLANK;
                if (status.scan_end_area)
                begin
                    cmd.cur_op = CUR_ZERO;
                    state_next = ST_DONE;
                end
                else
                    cmd.scan_op = SCAN_INC;
            end

            // Load the result once the output register is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_decode : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded next cycle");

    a_put_count_live : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |-> (put_left_reg != 3'd0))
        else $error("put with no remaining count");

    a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the finishing state");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_character_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_character_engine_top
// Text-mode console: character/attribute screen store with a linear cursor.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                         Contents
//  s_*       in         s_tvalid s_tready s_tdata/tuser one console request
//  m_*       out        m_tvalid m_tready m_tdata/tuser one result per request
//  cfg_*     in         cfg_we cfg_index cfg_wdata      rows (0), columns (1)
//
//  A newline runs the 12-step remainder unit; a scroll does a pipelined row
//  copy plus blanking of the last row, and a clear blanks the area in use.
//  After reset the whole store is swept blank with s_tready low.
//  One request is in flight at a time; a finished result waits in the output
//  register while the next request is taken.
// ----------------------------------------------------------------------------
module text_console_character_engine_top
    import tcce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] char_code, [15:8] attr_byte, [27:16] position, [40:28] offset
    input  wire logic [47:0] s_tdata,
    // [2:0] kind
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [11:0] cursor, [19:12] read_char, [27:20] read_attr
    output logic [31:0]      m_tdata,
    // [0] scrolled
    output logic             m_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [ADDR_W-1:0] res_cursor;
    logic [7:0]        res_char;
    logic [7:0]        res_attr;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tcce_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_kind      (s_tuser),
        .in_char      (s_tdata[7:0]),
        .in_attr      (s_tdata[15:8]),
        .in_pos       (s_tdata[27:16]),
        .in_off       (s_tdata[40:28]),
        .cmd          (cmd),
        .status       (status),
        .out_cursor   (res_cursor),
        .out_char     (res_char),
        .out_attr     (res_attr),
        .out_scrolled (m_tuser)
    );

    // Pack the result
    assign m_tdata = {4'b0000, res_attr, res_char, res_cursor};

endmodule
`default_nettype wire
